@@ src/utu_pkg.sv @@
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder package
// Shared widths, code constants and the decode result type.
// ----------------------------------------------------------------------------
`default_nettype none

package utu_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned UNIT_W = 16;
   localparam int unsigned CP_W = 21;
   localparam int unsigned CONT_W = 2;
   localparam int unsigned MAX_UNITS = 3;
   localparam int unsigned COUNT_W = 2;

   localparam logic [UNIT_W-1:0] REPLACEMENT_CHAR = 16'hFFFD;
   localparam logic [UNIT_W-1:0] HIGH_SURROGATE_BASE = 16'hD800;
   localparam logic [UNIT_W-1:0] LOW_SURROGATE_BASE = 16'hDC00;
   localparam logic [CP_W-1:0] SUPPLEMENTARY_BASE = 21'h10000;

   typedef logic [UNIT_W-1:0] unit_type;

   typedef struct packed {
      unit_type [MAX_UNITS-1:0] units;
      logic [COUNT_W-1:0] count;
   } dec_type;

endpackage : utu_pkg

`default_nettype wire

@@ src/utu_decode.sv @@
// ----------------------------------------------------------------------------
// UTF-8 byte decoder
// Combines one byte with the pending code point state and produces the
// UTF-16 units that this byte releases, along with the next state.
// ----------------------------------------------------------------------------
`default_nettype none

module utu_decode (
   input  wire logic [utu_pkg::BYTE_W-1:0] in_byte,
   input  wire logic [utu_pkg::CONT_W-1:0] cont_left,
   input  wire logic [utu_pkg::CP_W-1:0]   partial,
   output utu_pkg::dec_type                result,
   output logic [utu_pkg::CONT_W-1:0]      cont_left_next,
   output logic [utu_pkg::CP_W-1:0]        partial_next
);

   logic                      is_cont;
   logic [utu_pkg::CP_W-1:0]  cont_bits;
   logic [utu_pkg::CP_W-1:0]  merged;
   logic [utu_pkg::CP_W-1:0]  emit_cp;
   logic                      emit_en;
   logic [utu_pkg::CP_W-1:0]  offset;
   logic                      emit_pair;
   utu_pkg::unit_type         emit_hi;
   utu_pkg::unit_type         emit_lo;
   logic [1:0]                first_count;
   logic                      byte_valid;
   utu_pkg::unit_type         byte_unit;

   assign is_cont = (in_byte[7:6] == 2'b10);

   always_comb begin
      unique case (cont_left)
         2'd1: cont_bits = {15'd0, in_byte[5:0]};
         2'd2: cont_bits = {9'd0, in_byte[5:0], 6'd0};
         2'd3: cont_bits = {3'd0, in_byte[5:0], 12'd0};
         default: cont_bits = '0;
      endcase
   end

   assign merged = partial | cont_bits;

   // Units of the code point being released: a completed one, or a pending
   // one that is cut short by a byte that is not a continuation.
   assign emit_cp = (is_cont) ? merged : partial;
   assign emit_en = (cont_left != '0) && (!is_cont || (cont_left == 2'd1));
   assign emit_pair = (emit_cp >= utu_pkg::SUPPLEMENTARY_BASE);
   assign offset = emit_cp - utu_pkg::SUPPLEMENTARY_BASE;
   assign emit_hi = emit_pair
      ? utu_pkg::HIGH_SURROGATE_BASE + {5'd0, offset[20:10]}
      : emit_cp[15:0];
   assign emit_lo = utu_pkg::LOW_SURROGATE_BASE | {6'd0, offset[9:0]};

   always_comb begin
      if (!emit_en) begin
         first_count = 2'd0;
      end else if (emit_pair) begin
         first_count = 2'd2;
      end else begin
         first_count = 2'd1;
      end
   end

   always_comb begin
      byte_valid = 1'b0;
      byte_unit = utu_pkg::REPLACEMENT_CHAR;
      cont_left_next = '0;
      partial_next = '0;
      if ((cont_left != '0) && is_cont) begin
         cont_left_next = cont_left - 2'd1;
         partial_next = (cont_left == 2'd1) ? '0 : merged;
      end else begin
         priority if (in_byte == '0) begin
            byte_valid = 1'b0;
         end else if (in_byte[7] == 1'b0) begin
            byte_valid = 1'b1;
            byte_unit = {8'd0, in_byte};
         end else if (in_byte[7:5] == 3'b110) begin
            cont_left_next = 2'd1;
            partial_next = {10'd0, in_byte[4:0], 6'd0};
         end else if (in_byte[7:4] == 4'b1110) begin
            cont_left_next = 2'd2;
            partial_next = {5'd0, in_byte[3:0], 12'd0};
         end else if (in_byte[7:3] == 5'b11110) begin
            cont_left_next = 2'd3;
            partial_next = {in_byte[2:0], 18'd0};
         end else begin
            byte_valid = 1'b1;
            byte_unit = utu_pkg::REPLACEMENT_CHAR;
         end
      end
   end

   always_comb begin
      result.units[0] = (first_count == 2'd0) ? byte_unit : emit_hi;
      result.units[1] = (first_count == 2'd2) ? emit_lo : byte_unit;
      result.units[2] = byte_unit;
      result.count = first_count + {1'b0, byte_valid};
   end

endmodule : utu_decode

`default_nettype wire

@@ src/utf8_to_utf16_transcoder.sv @@
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder
// UTF-8 bytes enter on the req channel, one per beat. UTF-16 code units
// leave on the rsp channel, one per beat, with rsp_last_unit set on the
// final unit released by a byte. A zero byte ends the string and flushes
// any partial code point; it releases no unit of its own.
// Each accepted byte is decoded in the accepting cycle into a small unit
// buffer of up to three entries, and the buffer feeds an output register.
// The units of a byte pass from the unit buffer through the output register
// to rsp. While rsp_stall is low, a plain text stream of bytes that release
// one unit or none runs at one byte per cycle; a byte that releases more
// units holds req_stall while the buffer drains.
// When the receiver raises rsp_stall, the output register holds its beat,
// and bytes are still accepted until one of them leaves units in the
// buffer; req_stall then rises.
// Reset clears the pending code point, the buffer and the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_to_utf16_transcoder (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [utu_pkg::BYTE_W-1:0]   req_in_byte,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [utu_pkg::UNIT_W-1:0]        rsp_utf16_unit,
   output logic                              rsp_last_unit
);

   logic [utu_pkg::CONT_W-1:0]   cont_left_ff;
   logic [utu_pkg::CONT_W-1:0]   cont_left_in;
   logic [utu_pkg::CP_W-1:0]     partial_ff;
   logic [utu_pkg::CP_W-1:0]     partial_in;
   utu_pkg::dec_type             dec_result;
   utu_pkg::unit_type [utu_pkg::MAX_UNITS-1:0] units_ff;
   logic [utu_pkg::COUNT_W-1:0]  count_ff;
   logic                         out_valid_ff;
   utu_pkg::unit_type            out_unit_ff;
   logic                         out_last_ff;
   logic                         move;
   logic                         accept;

   utu_decode u_decode (
      .in_byte        (req_in_byte),
      .cont_left      (cont_left_ff),
      .partial        (partial_ff),
      .result         (dec_result),
      .cont_left_next (cont_left_in),
      .partial_next   (partial_in)
   );

   assign move = (count_ff != '0) && (!out_valid_ff || !rsp_stall);
   assign req_stall = !((count_ff == '0) || ((count_ff == 2'd1) && move));
   assign accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         cont_left_ff <= '0;
         partial_ff <= '0;
         count_ff <= '0;
      end else if (accept) begin
         cont_left_ff <= cont_left_in;
         partial_ff <= partial_in;
         count_ff <= dec_result.count;
      end else if (move) begin
         count_ff <= count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         units_ff <= dec_result.units;
      end else if (move) begin
         units_ff[0] <= units_ff[1];
         units_ff[1] <= units_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (move) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         out_unit_ff <= units_ff[0];
         out_last_ff <= (count_ff == 2'd1);
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_utf16_unit = out_unit_ff;
   assign rsp_last_unit = out_last_ff;

`ifndef SYNTHESIS
   a_accept_empty: assert property (@(posedge clock) disable iff (reset)
      accept |-> ((count_ff == '0) || ((count_ff == 2'd1) && move)))
      else $error("Byte accepted while the unit buffer still holds units.");

   a_idle_partial: assert property (@(posedge clock) disable iff (reset)
      (cont_left_ff == '0) |-> (partial_ff == '0))
      else $error("Partial code point held with no continuation expected.");

   a_buffer_feeds: assert property (@(posedge clock) disable iff (reset)
      ((count_ff != '0) && !out_valid_ff) |=> out_valid_ff)
      else $error("Buffered unit did not reach the output register.");

   a_last_drains: assert property (@(posedge clock) disable iff (reset)
      (move && (count_ff == 2'd1) && !accept) |=> (count_ff == '0))
      else $error("Unit buffer did not empty after its last unit moved.");
`endif

endmodule : utf8_to_utf16_transcoder

`default_nettype wire
